### sv/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define TLR_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

### sv/tlr_pkg.sv
package tlr_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int PERIOD_W       = 10;
  localparam int PHASE_W        = 11;
  localparam int CFG_INDEX_W    = 2;
  localparam int DIFF_W         = SAMPLE_W + 1;
  localparam int PROD_W         = 28;
  localparam int MAG_W          = 26;
  localparam int SUM_W          = SAMPLE_W + 2;
  localparam int DEF_MAX_POINTS = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_PERIOD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_PERIOD = 2'd1;

  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 10'd80;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic                start;
    sample_t             a0;
    sample_t             a1;
    logic [PERIOD_W-1:0] t;
    logic [PERIOD_W-1:0] span;
  } tlr_req_t;

  typedef struct packed {
    logic    done;
    sample_t value;
  } tlr_rsp_t;

  function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] v);
    return (v == '0) ? {{(PERIOD_W-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

### sv/tlr_lerp_unit.sv
module tlr_lerp_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  tlr_pkg::tlr_req_t  req_i,
  output tlr_pkg::tlr_rsp_t  rsp_o
);
  import tlr_pkg::*;

  `include "assert_macros.svh"

  localparam int STEP_W = $clog2(MAG_W);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;
  localparam logic [1:0] U_FIN  = 2'd3;

  logic [1:0]               ust_r, ust_nxt;
  logic                     done_r, done_nxt;
  sample_t                  a0_r, a0_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic [PERIOD_W-1:0]      t_r, t_nxt;
  logic [PERIOD_W-1:0]      span_r, span_nxt;
  logic                     neg_r, neg_nxt;
  logic [MAG_W-1:0]         dv_r, dv_nxt;
  logic [PERIOD_W-1:0]      rem_r, rem_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  sample_t                  value_r, value_nxt;

  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        prod_mag;
  logic [PERIOD_W:0]        trial;
  logic [PERIOD_W:0]        trial_sub;
  logic                     ge;
  logic signed [SUM_W-1:0]  qs;
  logic signed [SUM_W-1:0]  sum;

  assign prod = $signed({{(PROD_W-PERIOD_W){1'b0}}, t_r})
              * $signed({{(PROD_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r});
  assign prod_mag  = prod[PROD_W-1] ? -prod : prod;
  assign trial     = {rem_r, dv_r[MAG_W-1]};
  assign ge        = trial >= {1'b0, span_r};
  assign trial_sub = trial - {1'b0, span_r};
  assign qs  = neg_r ? -$signed({2'b00, dv_r[SAMPLE_W-1:0]})
                     :  $signed({2'b00, dv_r[SAMPLE_W-1:0]});
  assign sum = $signed({{(SUM_W-SAMPLE_W){a0_r[SAMPLE_W-1]}}, a0_r}) + qs;

  always_comb begin
    ust_nxt   = ust_r;
    done_nxt  = 1'b0;
    a0_nxt    = a0_r;
    diff_nxt  = diff_r;
    t_nxt     = t_r;
    span_nxt  = span_r;
    neg_nxt   = neg_r;
    dv_nxt    = dv_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    value_nxt = value_r;
    case (ust_r)
      U_IDLE: begin
        if (req_i.start) begin
          a0_nxt   = req_i.a0;
          diff_nxt = $signed({req_i.a1[SAMPLE_W-1], req_i.a1})
                   - $signed({req_i.a0[SAMPLE_W-1], req_i.a0});
          t_nxt    = req_i.t;
          span_nxt = req_i.span;
          ust_nxt  = U_MUL;
        end
      end
      U_MUL: begin
        dv_nxt   = prod_mag[MAG_W-1:0];
        neg_nxt  = prod[PROD_W-1];
        rem_nxt  = '0;
        step_nxt = '0;
        ust_nxt  = U_DIV;
      end
      U_DIV: begin
        dv_nxt  = {dv_r[MAG_W-2:0], ge};
        rem_nxt = ge ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        if (step_r == STEP_W'(MAG_W - 1)) begin
          ust_nxt = U_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      U_FIN: begin
        value_nxt = sum[SAMPLE_W-1:0];
        done_nxt  = 1'b1;
        ust_nxt   = U_IDLE;
      end
      default: begin
        ust_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r  <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      ust_r  <= ust_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a0_r    <= a0_nxt;
    diff_r  <= diff_nxt;
    t_r     <= t_nxt;
    span_r  <= span_nxt;
    neg_r   <= neg_nxt;
    dv_r    <= dv_nxt;
    rem_r   <= rem_nxt;
    step_r  <= step_nxt;
    value_r <= value_nxt;
  end

  assign rsp_o.done  = done_r;
  assign rsp_o.value = value_r;

  `TLR_ASSERT(a_start_idle, req_i.start |-> ust_r == U_IDLE, "start while unit busy")
  `TLR_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "done held over two cycles")
  `TLR_ASSERT(a_rem_bound, ust_r == U_DIV |-> rem_r < span_r, "remainder not below divisor")

endmodule

### sv/three_axis_linear_resampler.sv
// A primer item, or one whose phase lies past the input period, is absorbed in S_IDLE.
// Otherwise each emitted point passes S_CHECK, then three axes on the shared multiply/divide
// unit (multiply, 26 restoring-division steps, finish), then S_OUT, which waits on out_stall,
// and S_STEP; points skipped beyond the run cap pass only through S_CHECK and S_STEP.
// No item is taken until the run ends and the FSM is back in S_IDLE.
// Reset (rst_n low, synchronous): both periods 80, phase 80, no sample held.
module three_axis_linear_resampler #(
  parameter int MAX_POINTS_PER_SAMPLE = tlr_pkg::DEF_MAX_POINTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tlr_pkg::SAMPLE_W-1:0]  in_sample_x,
  input  logic signed [tlr_pkg::SAMPLE_W-1:0]  in_sample_y,
  input  logic signed [tlr_pkg::SAMPLE_W-1:0]  in_sample_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tlr_pkg::SAMPLE_W-1:0]  out_x,
  output logic signed [tlr_pkg::SAMPLE_W-1:0]  out_y,
  output logic signed [tlr_pkg::SAMPLE_W-1:0]  out_z,
  output logic                                 out_last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tlr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [tlr_pkg::PERIOD_W-1:0]         cfg_data
);
  import tlr_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_POINTS_PER_SAMPLE + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  logic [2:0]          state_r, state_nxt;
  logic [PERIOD_W-1:0] in_period_r, in_period_nxt;
  logic [PERIOD_W-1:0] out_period_r, out_period_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic                primed_r, primed_nxt;
  sample_t             prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt, prev_z_r, prev_z_nxt;
  sample_t             new_x_r, new_x_nxt, new_y_r, new_y_nxt, new_z_r, new_z_nxt;
  sample_t             out_x_r, out_x_nxt, out_y_r, out_y_nxt, out_z_r, out_z_nxt;
  logic                out_last_r, out_last_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [1:0]          axis_r, axis_nxt;
  logic                start_r, start_nxt;

  logic [PERIOD_W-1:0] tin;
  logic [PERIOD_W-1:0] tout;
  logic [PHASE_W-1:0]  phase_sum;
  logic                run_end;
  logic                in_acc;
  logic                cfg_acc;
  tlr_req_t            req;
  tlr_rsp_t            rsp;

  assign tin       = eff_period(in_period_r);
  assign tout      = eff_period(out_period_r);
  assign phase_sum = phase_r + {1'b0, tout};
  assign run_end   = phase_sum >= {1'b0, tin};

  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = state_r == S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    req.start = start_r;
    req.t     = phase_r[PERIOD_W-1:0];
    req.span  = tin;
    case (axis_r)
      AXIS_X: begin
        req.a0 = prev_x_r;
        req.a1 = new_x_r;
      end
      AXIS_Y: begin
        req.a0 = prev_y_r;
        req.a1 = new_y_r;
      end
      default: begin
        req.a0 = prev_z_r;
        req.a1 = new_z_r;
      end
    endcase
  end

  tlr_lerp_unit u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    in_period_nxt  = in_period_r;
    out_period_nxt = out_period_r;
    phase_nxt      = phase_r;
    primed_nxt     = primed_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    prev_z_nxt     = prev_z_r;
    new_x_nxt      = new_x_r;
    new_y_nxt      = new_y_r;
    new_z_nxt      = new_z_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_z_nxt      = out_z_r;
    out_last_nxt   = out_last_r;
    count_nxt      = count_r;
    axis_nxt       = axis_r;
    start_nxt      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          case (cfg_index)
            REG_INPUT_PERIOD: begin
              in_period_nxt = cfg_data;
              phase_nxt     = {1'b0, tout};
            end
            REG_OUTPUT_PERIOD: begin
              out_period_nxt = cfg_data;
              phase_nxt      = {1'b0, eff_period(cfg_data)};
            end
            default: begin
            end
          endcase
        end else if (in_acc) begin
          new_x_nxt = in_sample_x;
          new_y_nxt = in_sample_y;
          new_z_nxt = in_sample_z;
          if (!primed_r) begin
            primed_nxt = 1'b1;
            prev_x_nxt = in_sample_x;
            prev_y_nxt = in_sample_y;
            prev_z_nxt = in_sample_z;
          end else if (phase_r > {1'b0, tin}) begin
            phase_nxt  = phase_r - {1'b0, tin};
            prev_x_nxt = in_sample_x;
            prev_y_nxt = in_sample_y;
            prev_z_nxt = in_sample_z;
          end else begin
            count_nxt = '0;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (count_r < CNT_W'(MAX_POINTS_PER_SAMPLE)) begin
          axis_nxt  = AXIS_X;
          start_nxt = 1'b1;
          state_nxt = S_CALC;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_CALC: begin
        if (rsp.done) begin
          case (axis_r)
            AXIS_X: out_x_nxt = rsp.value;
            AXIS_Y: out_y_nxt = rsp.value;
            default: out_z_nxt = rsp.value;
          endcase
          if (axis_r == AXIS_Z) begin
            out_last_nxt = run_end || (count_r == CNT_W'(MAX_POINTS_PER_SAMPLE - 1));
            state_nxt    = S_OUT;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            start_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          count_nxt = count_r + 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (run_end) begin
          phase_nxt  = phase_sum - {1'b0, tin};
          prev_x_nxt = new_x_r;
          prev_y_nxt = new_y_r;
          prev_z_nxt = new_z_r;
          state_nxt  = S_IDLE;
        end else begin
          phase_nxt = phase_sum;
          state_nxt = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_period_r  <= RESET_PERIOD;
      out_period_r <= RESET_PERIOD;
      phase_r      <= {1'b0, RESET_PERIOD};
      primed_r     <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_z_r     <= '0;
      count_r      <= '0;
      start_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_period_r  <= in_period_nxt;
      out_period_r <= out_period_nxt;
      phase_r      <= phase_nxt;
      primed_r     <= primed_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_y_r     <= prev_y_nxt;
      prev_z_r     <= prev_z_nxt;
      count_r      <= count_nxt;
      start_r      <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_x_r    <= new_x_nxt;
    new_y_r    <= new_y_nxt;
    new_z_r    <= new_z_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_z_r    <= out_z_nxt;
    out_last_r <= out_last_nxt;
    axis_r     <= axis_nxt;
  end

  assign out_valid       = state_r == S_OUT;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_z           = out_z_r;
  assign out_last_of_run = out_last_r;

  `TLR_ASSERT(a_loop_phase, state_r == S_CHECK |-> phase_r <= {1'b0, tin},
              "phase beyond input period in run")
  `TLR_ASSERT(a_count_cap, count_r <= CNT_W'(MAX_POINTS_PER_SAMPLE), "point count above cap")
  `TLR_ASSERT(a_done_in_calc, rsp.done |-> state_r == S_CALC, "unit result outside calculation")
  `TLR_ASSERT_NEXT(a_last_ends, out_valid && !out_stall && out_last_of_run,
                   state_r == S_STEP && (run_end || count_r == CNT_W'(MAX_POINTS_PER_SAMPLE)),
                   "last item without run end")

endmodule
